// ----- design/sql_lex_pkg.sv -----
// Shared types, codes and the keyword table of the SQL statement lexer.
`default_nettype none
package sql_lex_pkg;

  localparam int TEXT_MAX_DEF = 8;
  localparam int FIFO_DEPTH   = 4;
  localparam int NKEYWORDS    = 28;
  localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_IDENT, MODE_INT, MODE_FRAC, MODE_STR, MODE_LT, MODE_GT, MODE_EQ
  } lex_mode_t;

  // token kinds
  localparam logic [4:0] TK_KEYWORD = 5'd0;
  localparam logic [4:0] TK_IDENT   = 5'd1;
  localparam logic [4:0] TK_INT     = 5'd2;
  localparam logic [4:0] TK_DEC     = 5'd3;
  localparam logic [4:0] TK_STR     = 5'd4;
  localparam logic [4:0] TK_LT      = 5'd5;
  localparam logic [4:0] TK_LE      = 5'd6;
  localparam logic [4:0] TK_GT      = 5'd7;
  localparam logic [4:0] TK_GE      = 5'd8;
  localparam logic [4:0] TK_EQ      = 5'd9;
  localparam logic [4:0] TK_LPAREN  = 5'd10;
  localparam logic [4:0] TK_RPAREN  = 5'd11;
  localparam logic [4:0] TK_PLUS    = 5'd12;
  localparam logic [4:0] TK_MINUS   = 5'd13;
  localparam logic [4:0] TK_TIMES   = 5'd14;
  localparam logic [4:0] TK_SLASH   = 5'd15;
  localparam logic [4:0] TK_SEMI    = 5'd16;
  localparam logic [4:0] TK_COMMA   = 5'd17;
  localparam logic [4:0] TK_END     = 5'd18;

  // keyword ids used by statement classification
  localparam logic [5:0] KW_CREATE   = 6'd1;
  localparam logic [5:0] KW_DATABASE = 6'd2;
  localparam logic [5:0] KW_DELETE   = 6'd3;
  localparam logic [5:0] KW_DESC     = 6'd4;
  localparam logic [5:0] KW_DROP     = 6'd5;
  localparam logic [5:0] KW_EDIT     = 6'd6;
  localparam logic [5:0] KW_FROM     = 6'd7;
  localparam logic [5:0] KW_INSERT   = 6'd9;
  localparam logic [5:0] KW_INTO     = 6'd10;
  localparam logic [5:0] KW_RENAME   = 6'd16;
  localparam logic [5:0] KW_TABLE    = 6'd19;
  localparam logic [5:0] KW_UPDATE   = 6'd20;
  localparam logic [5:0] KW_USE      = 6'd21;
  localparam logic [5:0] CODE_NONE   = 6'd63;

  // statement kinds
  localparam logic [3:0] SK_UNKNOWN   = 4'd0;
  localparam logic [3:0] SK_ERROR     = 4'd1;
  localparam logic [3:0] SK_CREATE_TB = 4'd2;
  localparam logic [3:0] SK_EDIT      = 4'd3;
  localparam logic [3:0] SK_RENAME    = 4'd4;
  localparam logic [3:0] SK_DROP      = 4'd5;
  localparam logic [3:0] SK_INSERT    = 4'd6;
  localparam logic [3:0] SK_DELETE    = 4'd7;
  localparam logic [3:0] SK_UPDATE    = 4'd8;
  localparam logic [3:0] SK_CREATE_DB = 4'd9;
  localparam logic [3:0] SK_USE       = 4'd10;
  localparam logic [3:0] SK_DESC      = 4'd11;

  // string literals are right-justified: last character in the low byte
  localparam logic [63:0] KW_STR [NKEYWORDS] = '{
    "AND", "CREATE", "DATABASE", "DELETE", "DESC", "DROP", "EDIT", "FROM",
    "IN", "INSERT", "INTO", "INVALID", "KEY", "NOT_KEY", {"NOT_", "NULL"}, "NULL",
    "RENAME", "SELECT", "SET", "TABLE", "UPDATE", "USE", "VALID", "VALUES",
    "WHERE", "datetime", "int", "varchar"
  };
  localparam int KW_LEN [NKEYWORDS] = '{
    3, 6, 8, 6, 4, 4, 4, 4, 2, 6, 4, 7, 3, 7, 8, 4,
    6, 6, 3, 5, 6, 3, 5, 6, 5, 8, 3, 7
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [4:0]  kw;
    logic [63:0] text;
    logic [3:0]  len;
    logic [30:0] iv;
    logic [30:0] fv;
    logic [3:0]  fd;
  } lex_tok_t;

  typedef struct packed {
    lex_tok_t   tok;
    logic       done;
    logic [3:0] sk;
    logic       last;
  } lex_res_t;

  typedef struct packed {
    lex_mode_t   mode;
    logic [63:0] text;
    logic [3:0]  cnt;
    logic [30:0] iacc;
    logic [30:0] facc;
    logic [3:0]  fcnt;
    logic [5:0]  first;
    logic [5:0]  second;
    logic [1:0]  seen;
    logic        err;
  } lex_state_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] id;
  } kw_hit_t;

  function automatic kw_hit_t kw_lookup(input logic [63:0] text, input logic [3:0] len);
    kw_hit_t r;
    logic    same;
    logic [7:0] want;
    r = '0;
    for (int k = NKEYWORDS - 1; k >= 0; k--) begin
      same = (len == 4'(KW_LEN[k]));
      for (int j = 0; j < 8; j++) begin
        if (j < KW_LEN[k]) want = 8'(KW_STR[k] >> (8 * (KW_LEN[k] - 1 - j)));
        else want = 8'h00;
        if (text[8*j +: 8] != want) same = 1'b0;
      end
      if (same) begin
        r.hit = 1'b1;
        r.id  = 5'(k);
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] stmt_kind(input logic [5:0] first, input logic [5:0] second,
                                           input logic [1:0] seen, input logic err);
    logic [5:0] a, b;
    logic [3:0] r;
    a = (seen < 2'd1) ? CODE_NONE : first;
    b = (seen < 2'd2) ? CODE_NONE : second;
    if (err) r = SK_ERROR;
    else if (a == KW_CREATE && b == KW_TABLE) r = SK_CREATE_TB;
    else if (a == KW_EDIT && b == KW_TABLE) r = SK_EDIT;
    else if (a == KW_RENAME && b == KW_TABLE) r = SK_RENAME;
    else if (a == KW_DROP && b == KW_TABLE) r = SK_DROP;
    else if (a == KW_INSERT && b == KW_INTO) r = SK_INSERT;
    else if (a == KW_DELETE && b == KW_FROM) r = SK_DELETE;
    else if (a == KW_UPDATE) r = SK_UPDATE;
    else if (a == KW_CREATE && b == KW_DATABASE) r = SK_CREATE_DB;
    else if (a == KW_USE) r = SK_USE;
    else if (a == KW_DESC) r = SK_DESC;
    else r = SK_UNKNOWN;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/sql_lex_step.sv -----
// Combinational lexer step: one character against the state, up to two results.
`default_nettype none
module sql_lex_step #(
  parameter int TEXT_MAX = sql_lex_pkg::TEXT_MAX_DEF
) (
  input  wire logic [7:0]             c,
  input  wire sql_lex_pkg::lex_state_t st,
  output sql_lex_pkg::lex_state_t     st_nxt,
  output sql_lex_pkg::lex_res_t       res0,
  output sql_lex_pkg::lex_res_t       res1,
  output logic [1:0]                  n_res
);

  function automatic logic is_letter(input logic [7:0] x);
    return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] x);
    return x >= "0" && x <= "9";
  endfunction

  function automatic logic [30:0] sat_acc(input logic [30:0] acc, input logic [7:0] x);
    logic [34:0] v;
    v = {4'd0, acc} * 35'd10 + 35'(x - "0");
    return (v > 35'(sql_lex_pkg::VAL_MAX)) ? sql_lex_pkg::VAL_MAX : v[30:0];
  endfunction

  function automatic sql_lex_pkg::lex_tok_t op_tok(input logic [4:0] kind,
                                                   input logic [15:0] txt,
                                                   input logic [3:0] len);
    sql_lex_pkg::lex_tok_t t;
    t = '0;
    t.kind = kind;
    t.text = {48'd0, txt};
    t.len  = len;
    return t;
  endfunction

  sql_lex_pkg::lex_state_t  s;
  sql_lex_pkg::lex_tok_t    toks [2];
  sql_lex_pkg::lex_tok_t    t;
  sql_lex_pkg::lex_res_t    r [2];
  sql_lex_pkg::kw_hit_t     kh;
  logic [1:0] n;
  logic       do_start;
  logic [5:0] code;

  always_comb begin
    s        = st;
    n        = 2'd0;
    toks[0]  = '0;
    toks[1]  = '0;
    t        = '0;
    do_start = 1'b0;
    kh       = sql_lex_pkg::kw_lookup(st.text, st.cnt);

    case (st.mode)
      sql_lex_pkg::MODE_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == "_") begin
          if (s.cnt < 4'(TEXT_MAX)) begin
            s.text[{s.cnt[2:0], 3'b000} +: 8] = c;
            s.cnt = s.cnt + 4'd1;
          end
        end else begin
          t.kind = kh.hit ? sql_lex_pkg::TK_KEYWORD : sql_lex_pkg::TK_IDENT;
          t.kw   = kh.hit ? kh.id : 5'd0;
          t.text = st.text;
          t.len  = st.cnt;
          toks[0] = t;
          n = 2'd1;
          do_start = 1'b1;
        end
      end
      sql_lex_pkg::MODE_INT: begin
        if (is_digit(c) || c == ".") begin
          if (is_digit(c)) s.iacc = sat_acc(st.iacc, c);
          else s.mode = sql_lex_pkg::MODE_FRAC;
          if (s.cnt < 4'(TEXT_MAX)) begin
            s.text[{s.cnt[2:0], 3'b000} +: 8] = c;
            s.cnt = s.cnt + 4'd1;
          end
        end else begin
          t.kind = sql_lex_pkg::TK_INT;
          t.text = st.text;
          t.len  = st.cnt;
          t.iv   = st.iacc;
          toks[0] = t;
          n = 2'd1;
          do_start = 1'b1;
        end
      end
      sql_lex_pkg::MODE_FRAC: begin
        if (is_digit(c)) begin
          s.facc = sat_acc(st.facc, c);
          if (st.fcnt < 4'd15) s.fcnt = st.fcnt + 4'd1;
          if (s.cnt < 4'(TEXT_MAX)) begin
            s.text[{s.cnt[2:0], 3'b000} +: 8] = c;
            s.cnt = s.cnt + 4'd1;
          end
        end else begin
          t.kind = sql_lex_pkg::TK_DEC;
          t.text = st.text;
          t.len  = st.cnt;
          t.iv   = st.iacc;
          t.fv   = st.facc;
          t.fd   = st.fcnt;
          toks[0] = t;
          n = 2'd1;
          do_start = 1'b1;
        end
      end
      sql_lex_pkg::MODE_STR: begin
        if (c != "'" && c != 8'd0) begin
          if (s.cnt < 4'(TEXT_MAX)) begin
            s.text[{s.cnt[2:0], 3'b000} +: 8] = c;
            s.cnt = s.cnt + 4'd1;
          end
        end else begin
          if (st.cnt == 4'd0) begin
            s.err = 1'b1;
          end else begin
            t.kind = sql_lex_pkg::TK_STR;
            t.text = st.text;
            t.len  = st.cnt;
            toks[0] = t;
            n = 2'd1;
          end
          if (c == 8'd0) do_start = 1'b1;
          else begin
            s.mode = sql_lex_pkg::MODE_IDLE;
            s.text = '0;
            s.cnt  = '0;
            s.iacc = '0;
            s.facc = '0;
            s.fcnt = '0;
          end
        end
      end
      sql_lex_pkg::MODE_LT, sql_lex_pkg::MODE_GT, sql_lex_pkg::MODE_EQ: begin
        // two-character operators: first character in the low byte
        if (c == "=") begin
          case (st.mode)
            sql_lex_pkg::MODE_LT: toks[0] = op_tok(sql_lex_pkg::TK_LE, {"=", "<"}, 4'd2);
            sql_lex_pkg::MODE_GT: toks[0] = op_tok(sql_lex_pkg::TK_GE, {"=", ">"}, 4'd2);
            default:              toks[0] = op_tok(sql_lex_pkg::TK_EQ, "==", 4'd2);
          endcase
          s.mode = sql_lex_pkg::MODE_IDLE;
        end else begin
          case (st.mode)
            sql_lex_pkg::MODE_LT: toks[0] = op_tok(sql_lex_pkg::TK_LT, {8'd0, "<"}, 4'd1);
            sql_lex_pkg::MODE_GT: toks[0] = op_tok(sql_lex_pkg::TK_GT, {8'd0, ">"}, 4'd1);
            default:              toks[0] = op_tok(sql_lex_pkg::TK_EQ, {8'd0, "="}, 4'd1);
          endcase
          do_start = 1'b1;
        end
        n = 2'd1;
      end
      default: do_start = 1'b1;
    endcase

    // start of a new token from the current character
    if (do_start) begin
      s.mode = sql_lex_pkg::MODE_IDLE;
      s.text = '0;
      s.cnt  = '0;
      s.iacc = '0;
      s.facc = '0;
      s.fcnt = '0;
      t = '0;
      if (c == 8'd0) begin
        t.kind = sql_lex_pkg::TK_END;
        toks[n[0]] = t;
        n = n + 2'd1;
      end else if (is_letter(c) || is_digit(c) || c == ".") begin
        if (is_letter(c)) s.mode = sql_lex_pkg::MODE_IDENT;
        else if (is_digit(c)) begin
          s.mode = sql_lex_pkg::MODE_INT;
          s.iacc = 31'(c - "0");
        end else s.mode = sql_lex_pkg::MODE_FRAC;
        s.text[7:0] = c;
        s.cnt = 4'd1;
      end else begin
        case (c)
          "'": s.mode = sql_lex_pkg::MODE_STR;
          "<": s.mode = sql_lex_pkg::MODE_LT;
          ">": s.mode = sql_lex_pkg::MODE_GT;
          "=": s.mode = sql_lex_pkg::MODE_EQ;
          "(": t = op_tok(sql_lex_pkg::TK_LPAREN, {8'd0, c}, 4'd1);
          ")": t = op_tok(sql_lex_pkg::TK_RPAREN, {8'd0, c}, 4'd1);
          "+": t = op_tok(sql_lex_pkg::TK_PLUS,   {8'd0, c}, 4'd1);
          "-": t = op_tok(sql_lex_pkg::TK_MINUS,  {8'd0, c}, 4'd1);
          "*": t = op_tok(sql_lex_pkg::TK_TIMES,  {8'd0, c}, 4'd1);
          "/": t = op_tok(sql_lex_pkg::TK_SLASH,  {8'd0, c}, 4'd1);
          ";": t = op_tok(sql_lex_pkg::TK_SEMI,   {8'd0, c}, 4'd1);
          ",": t = op_tok(sql_lex_pkg::TK_COMMA,  {8'd0, c}, 4'd1);
          default: ;
        endcase
        if (t.len != 4'd0) begin
          toks[n[0]] = t;
          n = n + 2'd1;
        end
      end
    end

    // statement tracking, applied in emit order
    for (int i = 0; i < 2; i++) begin
      r[i]      = '0;
      r[i].tok  = toks[i];
      code      = (toks[i].kind == sql_lex_pkg::TK_KEYWORD) ? {1'b0, toks[i].kw}
                                                            : {1'b1, toks[i].kind};
      if (2'(i) < n) begin
        r[i].done = (toks[i].kind == sql_lex_pkg::TK_SEMI) ||
                    (toks[i].kind == sql_lex_pkg::TK_END);
        r[i].last = (2'(i + 1) == n);
        if (toks[i].kind != sql_lex_pkg::TK_END) begin
          if (s.seen == 2'd0) s.first = code;
          else if (s.seen == 2'd1) s.second = code;
          if (s.seen < 2'd2) s.seen = s.seen + 2'd1;
        end
        if (r[i].done) begin
          r[i].sk  = sql_lex_pkg::stmt_kind(s.first, s.second, s.seen, s.err);
          s.first  = '0;
          s.second = '0;
          s.seen   = '0;
          s.err    = 1'b0;
        end
      end
    end

    st_nxt = s;
    res0   = r[0];
    res1   = r[1];
    n_res  = n;
  end

endmodule
`default_nettype wire

// ----- design/sql_statement_lexer.sv -----
// Top level of the SQL statement lexer: state registers and result queue.
`default_nettype none
// Channel | Direction | Word
// in_     | input     | text_char (8), 0 ends the text
// out_    | output    | one token with its statement status
//
// One character is taken per cycle while in_stall is low; its token logic
// runs between the state registers and a four-word result queue. A character
// that closes one token and emits another produces two words, which leave the
// queue one at a time. in_stall rises while fewer than two queue slots are free.
// Reset clears lexer state and empties the queue. out_valid depends only on
// the queue fill.
module sql_statement_lexer #(
  parameter int TEXT_MAX = sql_lex_pkg::TEXT_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_token_kind,
  output logic [4:0]       out_keyword_id,
  output logic [63:0]      out_token_text,
  output logic [3:0]       out_text_length,
  output logic [30:0]      out_integer_value,
  output logic [30:0]      out_fraction_value,
  output logic [3:0]       out_fraction_digits,
  output logic             out_statement_done,
  output logic [3:0]       out_statement_kind,
  output logic             out_last_result
);

  localparam int PW = $clog2(sql_lex_pkg::FIFO_DEPTH);

  sql_lex_pkg::lex_state_t st_r, st_nxt;
  sql_lex_pkg::lex_res_t   res0, res1;
  sql_lex_pkg::lex_res_t   q_r [sql_lex_pkg::FIFO_DEPTH];
  logic [1:0]  n_res;
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;
  logic in_acc, out_acc;

  sql_lex_step #(.TEXT_MAX(TEXT_MAX)) u_step (
    .c      (in_text_char),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res0   (res0),
    .res1   (res1),
    .n_res  (n_res)
  );

  // room for two words must be free before a character is taken
  assign in_stall  = cnt_r > (PW + 1)'(sql_lex_pkg::FIFO_DEPTH - 2);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = cnt_r != '0;
  assign out_acc   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
        wr_r <= wr_r + PW'(n_res);
      end
      if (out_acc) rd_r <= rd_r + PW'(1);
      cnt_r <= cnt_r + (in_acc ? (PW + 1)'(n_res) : '0) - (out_acc ? (PW + 1)'(1) : '0);
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) q_r[wr_r] <= res0;
    if (in_acc && n_res == 2'd2) q_r[wr_r + PW'(1)] <= res1;
  end

  sql_lex_pkg::lex_res_t head;
  assign head = q_r[rd_r];

  assign out_token_kind      = head.tok.kind;
  assign out_keyword_id      = head.tok.kw;
  assign out_token_text      = head.tok.text;
  assign out_text_length     = head.tok.len;
  assign out_integer_value   = head.tok.iv;
  assign out_fraction_value  = head.tok.fv;
  assign out_fraction_digits = head.tok.fd;
  assign out_statement_done  = head.done;
  assign out_statement_kind  = head.sk;
  assign out_last_result     = head.last;

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the SQL statement lexer: token predictor, driver and monitor.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sql_lex_pkg::*;

  // one predicted token word
  typedef struct {
    logic [4:0]  kind;
    logic [4:0]  kw;
    logic [63:0] text;
    logic [3:0]  len;
    logic [30:0] iv;
    logic [30:0] fv;
    logic [3:0]  fd;
    logic        done;
    logic [3:0]  sk;
    logic        last;
  } token_word_t;

  localparam int IDLE_MAX   = 13;
  localparam int STALL_LONG = 60;
  localparam int WATCHDOG   = 5000;
  localparam int DRAIN      = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_char = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_token_kind;
  logic [4:0]  out_keyword_id;
  logic [63:0] out_token_text;
  logic [3:0]  out_text_length;
  logic [30:0] out_integer_value;
  logic [30:0] out_fraction_value;
  logic [3:0]  out_fraction_digits;
  logic        out_statement_done;
  logic [3:0]  out_statement_kind;
  logic        out_last_result;

  sql_statement_lexer dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_text_char,
    .out_valid, .out_stall, .out_token_kind, .out_keyword_id, .out_token_text,
    .out_text_length, .out_integer_value, .out_fraction_value,
    .out_fraction_digits, .out_statement_done, .out_statement_kind, .out_last_result
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------- token predictor ----------------
  lex_mode_t   p_mode;
  logic [63:0] p_text;
  logic [3:0]  p_cnt;
  logic [30:0] p_iacc, p_facc;
  logic [3:0]  p_fcnt;
  logic [5:0]  p_first, p_second;
  logic [1:0]  p_seen;
  logic        p_err;
  token_word_t char_words[$];   // words caused by the current character
  token_word_t expected_tokens[$];

  // keyword list, sorted, stored first char in low byte
  string keyword_names[NKEYWORDS] = '{
    "AND", "CREATE", "DATABASE", "DELETE", "DESC", "DROP", "EDIT", "FROM",
    "IN", "INSERT", "INTO", "INVALID", "KEY", "NOT_KEY", {"NOT_", "NULL"}, "NULL",
    "RENAME", "SELECT", "SET", "TABLE", "UPDATE", "USE", "VALID", "VALUES",
    "WHERE", "datetime", "int", "varchar"
  };

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [30:0] acc_digit(logic [30:0] acc, logic [7:0] c);
    logic [63:0] v;
    v = 64'(acc) * 10 + 64'(c - "0");
    return (v > 64'(VAL_MAX)) ? VAL_MAX : v[30:0];
  endfunction

  function automatic logic [3:0] classify(logic [5:0] a_in, logic [5:0] b_in);
    logic [5:0] a, b;
    a = (p_seen < 1) ? CODE_NONE : a_in;
    b = (p_seen < 2) ? CODE_NONE : b_in;
    if (p_err) return SK_ERROR;
    if (a == KW_CREATE && b == KW_TABLE) return SK_CREATE_TB;
    if (a == KW_EDIT && b == KW_TABLE) return SK_EDIT;
    if (a == KW_RENAME && b == KW_TABLE) return SK_RENAME;
    if (a == KW_DROP && b == KW_TABLE) return SK_DROP;
    if (a == KW_INSERT && b == KW_INTO) return SK_INSERT;
    if (a == KW_DELETE && b == KW_FROM) return SK_DELETE;
    if (a == KW_UPDATE) return SK_UPDATE;
    if (a == KW_CREATE && b == KW_DATABASE) return SK_CREATE_DB;
    if (a == KW_USE) return SK_USE;
    if (a == KW_DESC) return SK_DESC;
    return SK_UNKNOWN;
  endfunction

  task automatic push_token(logic [4:0] kind, logic [4:0] kw, logic [63:0] text,
                            logic [3:0] len, logic [30:0] iv, logic [30:0] fv,
                            logic [3:0] fd);
    token_word_t w;
    logic [5:0] code;
    w.kind = kind; w.kw = kw; w.text = text; w.len = len;
    w.iv = iv; w.fv = fv; w.fd = fd; w.last = 1'b0;
    w.done = (kind == TK_SEMI || kind == TK_END);
    w.sk = SK_UNKNOWN;
    if (kind != TK_END) begin
      code = (kind == TK_KEYWORD) ? 6'(kw) : 6'(32 + kind);
      if (p_seen == 0) p_first = code;
      else if (p_seen == 1) p_second = code;
      if (p_seen < 2) p_seen++;
    end
    if (w.done) begin
      w.sk = classify(p_first, p_second);
      p_first = '0; p_second = '0; p_seen = '0; p_err = 1'b0;
    end
    char_words.push_back(w);
  endtask

  task automatic push_op(logic [4:0] kind, logic [7:0] c0, logic [7:0] c1 = 8'h00);
    push_token(kind, '0, {48'h0, c1, c0}, (c1 != 0) ? 4'd2 : 4'd1, '0, '0, '0);
  endtask

  task automatic keep_char(logic [7:0] c);
    if (p_cnt < TEXT_MAX_DEF) begin
      p_text[8*p_cnt +: 8] = c;
      p_cnt++;
    end
  endtask

  task automatic close_word();
    logic [4:0] id;
    bit hit;
    hit = 1'b0; id = '0;
    for (int k = 0; k < NKEYWORDS && !hit; k++) begin
      if (keyword_names[k].len() == p_cnt) begin
        hit = 1'b1;
        for (int j = 0; j < p_cnt; j++)
          if (p_text[8*j +: 8] != keyword_names[k][j]) hit = 1'b0;
        if (hit) id = 5'(k);
      end
    end
    push_token(hit ? TK_KEYWORD : TK_IDENT, id, p_text, p_cnt, '0, '0, '0);
  endtask

  task automatic clear_scan();
    p_text = '0; p_cnt = '0; p_iacc = '0; p_facc = '0; p_fcnt = '0;
  endtask

  task automatic begin_token(logic [7:0] c);
    p_mode = MODE_IDLE;
    clear_scan();
    if (c == 8'h00) push_token(TK_END, '0, '0, '0, '0, '0, '0);
    else if (is_alpha(c)) begin
      p_mode = MODE_IDENT; keep_char(c);
    end else if (is_num(c)) begin
      p_mode = MODE_INT; p_iacc = 31'(c - "0"); keep_char(c);
    end else
      case (c)
        ".": begin p_mode = MODE_FRAC; keep_char(c); end
        "'": p_mode = MODE_STR;
        "<": p_mode = MODE_LT;
        ">": p_mode = MODE_GT;
        "=": p_mode = MODE_EQ;
        "(": push_op(TK_LPAREN, c);
        ")": push_op(TK_RPAREN, c);
        "+": push_op(TK_PLUS, c);
        "-": push_op(TK_MINUS, c);
        "*": push_op(TK_TIMES, c);
        "/": push_op(TK_SLASH, c);
        ";": push_op(TK_SEMI, c);
        ",": push_op(TK_COMMA, c);
        default: ;
      endcase
  endtask

  // advance the predictor by one character, queue resulting words
  task automatic predict_tokens(logic [7:0] c);
    char_words.delete();
    case (p_mode)
      MODE_IDENT:
        if (is_alpha(c) || is_num(c) || c == "_") keep_char(c);
        else begin close_word(); begin_token(c); end
      MODE_INT:
        if (is_num(c)) begin p_iacc = acc_digit(p_iacc, c); keep_char(c); end
        else if (c == ".") begin p_mode = MODE_FRAC; keep_char(c); end
        else begin
          push_token(TK_INT, '0, p_text, p_cnt, p_iacc, '0, '0);
          begin_token(c);
        end
      MODE_FRAC:
        if (is_num(c)) begin
          p_facc = acc_digit(p_facc, c);
          if (p_fcnt < 15) p_fcnt++;
          keep_char(c);
        end else begin
          push_token(TK_DEC, '0, p_text, p_cnt, p_iacc, p_facc, p_fcnt);
          begin_token(c);
        end
      MODE_STR:
        if (c != "'" && c != 8'h00) keep_char(c);
        else begin
          if (p_cnt == 0) p_err = 1'b1;   // empty string poisons the statement
          else push_token(TK_STR, '0, p_text, p_cnt, '0, '0, '0);
          if (c == 8'h00) begin_token(c);
          else begin p_mode = MODE_IDLE; clear_scan(); end
        end
      MODE_LT:
        if (c == "=") begin push_op(TK_LE, "<", "="); p_mode = MODE_IDLE; end
        else begin push_op(TK_LT, "<"); begin_token(c); end
      MODE_GT:
        if (c == "=") begin push_op(TK_GE, ">", "="); p_mode = MODE_IDLE; end
        else begin push_op(TK_GT, ">"); begin_token(c); end
      MODE_EQ:
        if (c == "=") begin push_op(TK_EQ, "=", "="); p_mode = MODE_IDLE; end
        else begin push_op(TK_EQ, "="); begin_token(c); end
      default: begin_token(c);
    endcase
    if (char_words.size() > 0) char_words[char_words.size()-1].last = 1'b1;
    foreach (char_words[i]) expected_tokens.push_back(char_words[i]);
  endtask

  // ---------------- stimulus ----------------
  logic [7:0] pending_chars[$];
  bit  hold_marks[$];     // sender waits for a quiet block before this char
  bit  stall_marks[$];    // receiver holds off long once this char is sent
  int  n_sent = 0, n_checked = 0, n_fail = 0, quiet = 0;
  bit  stimulus_done = 1'b0;
  bit  long_stall_req = 1'b0;

  task automatic add_text(string s);
    foreach (s[i]) begin
      pending_chars.push_back(s[i]); hold_marks.push_back(0); stall_marks.push_back(0);
    end
  endtask

  task automatic add_char(logic [7:0] c);
    pending_chars.push_back(c); hold_marks.push_back(0); stall_marks.push_back(0);
  endtask

  function automatic string rand_piece();
    string s;
    int n;
    case ($urandom_range(0, 13))
      0: s = "CREATE TABLE ";
      1: s = "CREATE DATABASE ";
      2: s = "INSERT INTO ";
      3: s = "DELETE FROM ";
      4: s = "UPDATE ";
      5: s = "DROP TABLE ";
      6: s = "USE ";
      7: s = "DESC ";
      8: s = "RENAME TABLE ";
      9: s = "EDIT TABLE ";
      10: s = "SELECT ";
      11: s = "varchar ";
      12: s = "WHERE ";
      default: s = {"NOT_", "NULL "};
    endcase
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++)
      case ($urandom_range(0, 7))
        0: s = {s, $sformatf("col%0d ", $urandom_range(0, 999))};
        1: s = {s, $sformatf("%0d", $urandom_range(0, 99999)), " "};
        2: s = {s, $sformatf("%0d.%0d ", $urandom_range(0, 99), $urandom_range(0, 999))};
        3: s = {s, "'", $sformatf("v%0d", $urandom), "' "};
        4: s = {s, "(a,b) "};
        5: s = {s, "<=b>c>=d==e=f<g "};
        6: s = {s, "+-*/ "};
        default: s = {s, "Abcdefghijk_1 "};
      endcase
    return s;
  endfunction

  initial begin
    // directed: keywords, every operator, long tokens, saturation, strings
    add_text("CREATE TABLE t1 (id int, nm varchar);");
    add_text("EDIT TABLE x;RENAME TABLE y;DROP TABLE z;DESC q;USE db;");
    add_text("UPDATE t SET a=1;DELETE FROM t WHERE a<=2;CREATE DATABASE d;");
    add_text("INSERT INTO t VALUES ('abc','');");          // empty string: error kind
    add_text("a<b>c>=d==e+f-g*h/i, .5 7. 99999999999.12345678901234567 ");
    add_text({"NOT_", "NULL datetime VeryLongIdentifier _ # 'a very long string' "});
    add_text("SELECT 'open");
    add_char(8'h00);                                        // end inside string
    add_char(8'h00);                                        // bare end
    add_char(8'hFF); add_char(8'h80); add_char(8'h7F);
    hold_marks[hold_marks.size()-1] = 1;
    while (pending_chars.size() < 1950) begin
      string s;
      s = rand_piece();
      if ($urandom_range(0, 9) == 0) begin
        int k;
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) s = {s, string'(8'($urandom_range(1, 255)))};
      end
      add_text(s);
      case ($urandom_range(0, 5))
        0: add_char(8'h00);
        1: ;
        default: add_char(";");
      endcase
      if ($urandom_range(0, 40) == 0) hold_marks[hold_marks.size()-1] = 1;
      if ($urandom_range(0, 60) == 0) stall_marks[stall_marks.size()-1] = 1;
    end
    stall_marks[40] = 1;
    hold_marks[600] = 1;
    add_char(8'h00);
  end

  // ---------------- driver ----------------
  int  send_gap = 0;
  bit  holding = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // stalled word stays put
    end else begin
      if (in_valid) begin
        predict_tokens(in_text_char);
        n_sent++;
        if (stall_marks.pop_front()) long_stall_req = 1'b1;
      end
      if (pending_chars.size() == 0) begin
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
      end else if (hold_marks[0] && (expected_tokens.size() != 0 || quiet < 4)) begin
        in_valid <= 1'b0;   // pause until the block drains
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else begin
        in_valid <= 1'b1;
        in_text_char <= pending_chars.pop_front();
        hold_marks[0] = 0;
        void'(hold_marks.pop_front());
        send_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
      end
    end
  end

  // ---------------- monitor / checker ----------------
  int stall_left = 0;
  int recv_gap = 0;
  always @(posedge clk) begin
    token_word_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_tokens.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected word kind=%0d", out_token_kind);
        end else begin
          e = expected_tokens.pop_front();
          if (out_token_kind !== e.kind || out_keyword_id !== e.kw ||
              out_token_text !== e.text || out_text_length !== e.len ||
              out_integer_value !== e.iv || out_fraction_value !== e.fv ||
              out_fraction_digits !== e.fd || out_statement_done !== e.done ||
              out_statement_kind !== e.sk || out_last_result !== e.last) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("mismatch word %0d: exp k%0d kw%0d t%h l%0d i%0d f%0d d%0d s%0b/%0d e%0b",
                n_checked, e.kind, e.kw, e.text, e.len, e.iv, e.fv, e.fd, e.done, e.sk,
                e.last);
              $display("  got k%0d kw%0d t%h l%0d i%0d f%0d d%0d s%0b/%0d e%0b",
                out_token_kind, out_keyword_id, out_token_text, out_text_length,
                out_integer_value, out_fraction_value, out_fraction_digits,
                out_statement_done, out_statement_kind, out_last_result);
            end
          end
        end
        // wait drawn per word before taking the next one
        recv_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, IDLE_MAX) : 0;
      end
      // receiver stall: a long hold-off on request, otherwise the drawn wait
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left = STALL_LONG;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap--;
      end else begin
        out_stall <= 1'b0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
  end

  // ---------------- run control ----------------
  initial begin
    int settle;
    settle = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    forever begin
      @(posedge clk);
      if (quiet >= WATCHDOG) begin
        $display("watchdog: no traffic for %0d cycles", WATCHDOG);
        $display("[FAIL] regression broken");
        $finish;
      end
      if (stimulus_done && expected_tokens.size() == 0) settle++;
      else settle = 0;
      if (settle >= DRAIN) break;
    end
    $display("%0d characters driven, %0d token words checked across", n_sent, n_checked);
    $display("keywords, numbers, strings, operators and statement kinds; %0d errors", n_fail);
    if (n_fail == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
